// ===== hdl/sprq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted priority ready queue: payload structs, slot and link types,
// operation codes. No dependencies.
package sprq_pkg;

    localparam int TASK_W = 8;
    localparam int PRIO_W = 8;

    // Operation codes; code three is undefined and does nothing
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    // Input transaction
    typedef struct packed {
        action_t           action;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
    } sprq_in_t;

    // Result transaction
    typedef struct packed {
        logic              success;
        logic [TASK_W-1:0] removed_task;
        logic              head_valid;
        logic [TASK_W-1:0] head_task;
        logic              is_full;
    } sprq_out_t;

    // Contents of one slot
    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [TASK_W-1:0] task_id;
    } sprq_slot_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic              ins;      // insert, queue known not full
        logic              del;      // pop or remove
        logic              pop;      // match any valid slot (first one is the head)
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } sprq_cmd_t;

    // Link passed from a cell to the one behind it (toward the tail)
    typedef struct packed {
        sprq_slot_t        slot;     // current contents of the cell
        logic              keep;     // cell stays put on insert
        logic              found;    // a match at this cell or nearer the head
        logic [TASK_W-1:0] rem_task; // task id of the first match, else 0
    } sprq_link_t;

endpackage

// ===== hdl/sorted_priority_ready_queue_core.sv =====
`timescale 1ns / 1ps
// Sorted priority ready queue: DEPTH slots, highest priority at the head, FIFO on ties.
// One transaction per cycle unless m_ready stalls; result valid the cycle after acceptance.
// All cells compare and shift in the same cycle; the match flag ripples head to tail.
// Reset (aresetn, synchronous, active low) empties the queue and drops the result register.
// Depends on sprq_pkg and sprq_cell.
module sorted_priority_ready_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sprq_pkg::sprq_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sprq_pkg::sprq_out_t m_data
);
    import sprq_pkg::*;

    sprq_link_t        link [DEPTH+1];
    sprq_slot_t        slot_q [DEPTH];
    sprq_slot_t        slot_n [DEPTH];
    logic [DEPTH-1:0]  valid_vec;
    sprq_cmd_t         cmd;
    logic              fire;
    logic              ins_ok;
    logic              m_valid_reg;
    sprq_out_t         m_data_reg;
    sprq_out_t         result_next;

    // Result register frees the input side
    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    // Decode the transaction into a cell command
    always_comb begin
        cmd         = '0;
        cmd.task_id = s_data.task_id;
        cmd.prio    = s_data.priority_req;
        unique case (s_data.action)
            ACT_INSERT: cmd.ins = fire && !valid_vec[DEPTH-1];
            ACT_POP: begin
                cmd.del = fire;
                cmd.pop = 1'b1;
            end
            ACT_REMOVE: cmd.del = fire;
            default: ;
        endcase
    end
    assign ins_ok = cmd.ins;

    // Head end of the chain
    always_comb begin
        link[0]          = '0;
        link[0].keep     = 1'b1;
    end

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sprq_slot_t next_in;
        if (i == DEPTH - 1) begin : g_tail
            assign next_in = '0;
        end else begin : g_body
            assign next_in = slot_q[i+1];
        end

        sprq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_link (link[i]),
            .next_slot (next_in),
            .link_out  (link[i+1]),
            .slot_q    (slot_q[i]),
            .slot_next (slot_n[i])
        );
        assign valid_vec[i] = slot_q[i].valid;
    end

    // Result from the post-operation state
    always_comb begin
        result_next.success      = ins_ok || (cmd.del && link[DEPTH].found);
        result_next.removed_task = cmd.del ? link[DEPTH].rem_task : '0;
        result_next.head_valid   = slot_n[0].valid;
        result_next.head_task    = slot_n[0].valid ? slot_n[0].task_id : '0;
        result_next.is_full      = slot_n[DEPTH-1].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire) begin
            m_data_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Occupied slots are packed toward the head
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & ~{valid_vec[DEPTH-2:0], 1'b1}) == '0)
        else $error("queue slots not contiguous");

    // Head never has lower priority than the slot behind it
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_vec[1] |-> (slot_q[0].prio >= slot_q[1].prio))
        else $error("queue head out of order");

    // A successful insert adds exactly one entry
    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_ok |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("insert did not add one entry");

    // A successful delete takes out exactly one entry
    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.del && link[DEPTH].found)
        |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
        else $error("delete did not remove one entry");
`endif

endmodule

// ===== hdl/sprq_cell.sv =====
`timescale 1ns / 1ps
// One queue slot of the shift-register priority queue.
// Depends on sprq_pkg.
module sprq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  sprq_pkg::sprq_cmd_t  cmd,
    input  sprq_pkg::sprq_link_t prev_link,
    input  sprq_pkg::sprq_slot_t next_slot,
    output sprq_pkg::sprq_link_t link_out,
    output sprq_pkg::sprq_slot_t slot_q,
    output sprq_pkg::sprq_slot_t slot_next
);
    import sprq_pkg::*;

    sprq_slot_t slot_reg;
    logic       keep;
    logic       match;
    logic       found_here;

    // Local decisions: stay on insert, match on delete
    assign keep       = slot_reg.valid && (slot_reg.prio >= cmd.prio);
    assign match      = slot_reg.valid && (cmd.pop || (slot_reg.task_id == cmd.task_id));
    assign found_here = prev_link.found || match;

    // Pass state toward the tail
    always_comb begin
        link_out.slot     = slot_reg;
        link_out.keep     = keep;
        link_out.found    = found_here;
        link_out.rem_task = (match && !prev_link.found) ? slot_reg.task_id
                                                        : prev_link.rem_task;
    end

    // Next contents: stay, take the new entry, shift from head side or from tail side
    always_comb begin
        slot_next = slot_reg;
        if (cmd.ins) begin
            if (keep) begin
                slot_next = slot_reg;
            end else if (prev_link.keep) begin
                slot_next.valid   = 1'b1;
                slot_next.prio    = cmd.prio;
                slot_next.task_id = cmd.task_id;
            end else begin
                slot_next = prev_link.slot;
            end
        end else if (cmd.del && found_here) begin
            slot_next = next_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
        slot_reg.prio    <= slot_next.prio;
        slot_reg.task_id <= slot_next.task_id;
    end

    assign slot_q = slot_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_ready_queue_core: directed rows, then random
// insert/pop/remove traffic checked against a behavioral queue. Depends on sprq_pkg, the DUT.
module testbench;
    import sprq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int RAND_ITEMS = 1420;
    localparam int CYC_LIMIT  = 400000;
    localparam int DRAIN_CYC  = 20;
    localparam int MAX_REPORT = 40;
    // Undefined operation code; the queue must leave its state alone
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    // Traffic mixes for the random part
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    // One directed row; typed rows carry a hand-written result
    typedef struct {
        sprq_in_t  op;
        bit        typed;
        sprq_out_t want;
    } drow_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sprq_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sprq_out_t m_data;

    // Side information held with the transaction on the input channel
    bit        typed_now = 1'b0;
    sprq_out_t typed_want = '0;

    // Behavioral queue: slots 0 .. queue_len-1 hold entries, slot 0 is the head
    logic [PRIO_W-1:0] queue_prio [QDEPTH];
    logic [TASK_W-1:0] queue_task [QDEPTH];
    int                queue_len = 0;

    sprq_out_t result_q [$];
    drow_t     dir_rows [$];
    int        err_cnt = 0;
    int        cyc = 0;
    int        burst_left = 0;
    mix_t      mix = MIX_EVEN;
    int        stall_mode = 0;
    int        stall_left = 0;

    sorted_priority_ready_queue_core #(.DEPTH(QDEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Take the entry at pos out, close the gap, clear the freed tail slot
    function automatic logic [TASK_W-1:0] drop_slot(int pos);
        logic [TASK_W-1:0] tid;
        int k;
        tid = queue_task[pos];
        for (k = pos; k + 1 < queue_len; k++) begin
            queue_prio[k] = queue_prio[k + 1];
            queue_task[k] = queue_task[k + 1];
        end
        queue_len--;
        queue_prio[queue_len] = '0;
        queue_task[queue_len] = '0;
        return tid;
    endfunction

    // Apply one operation to the behavioral queue and return the result it gives
    function automatic sprq_out_t predict_queue(sprq_in_t op);
        sprq_out_t r;
        int pos;
        int k;
        bit hit;
        r = '0;
        hit = 1'b0;
        case (op.action)
            ACT_INSERT: begin
                if (queue_len < QDEPTH) begin
                    // new entry goes behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < queue_len && queue_prio[pos] >= op.priority_req)
                        pos++;
                    for (k = queue_len; k > pos; k--) begin
                        queue_prio[k] = queue_prio[k - 1];
                        queue_task[k] = queue_task[k - 1];
                    end
                    queue_prio[pos] = op.priority_req;
                    queue_task[pos] = op.task_id;
                    queue_len++;
                    r.success = 1'b1;
                end
            end
            ACT_POP: begin
                if (queue_len > 0) begin
                    r.removed_task = drop_slot(0);
                    r.success = 1'b1;
                end
            end
            ACT_REMOVE: begin
                // first match from the head wins
                for (k = 0; k < queue_len; k++) begin
                    if (!hit && queue_task[k] == op.task_id) begin
                        r.removed_task = drop_slot(k);
                        r.success = 1'b1;
                        hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.head_valid = (queue_len > 0);
        r.head_task  = (queue_len > 0) ? queue_task[0] : '0;
        r.is_full    = (queue_len >= QDEPTH);
        return r;
    endfunction

    function automatic sprq_in_t mk_op(action_t a, logic [TASK_W-1:0] id,
                                       logic [PRIO_W-1:0] pr);
        sprq_in_t op;
        op.action = a;
        op.task_id = id;
        op.priority_req = pr;
        return op;
    endfunction

    function automatic sprq_out_t mk_res(logic ok, logic [TASK_W-1:0] rem, logic hv,
                                         logic [TASK_W-1:0] ht, logic full);
        sprq_out_t r;
        r.success = ok;
        r.removed_task = rem;
        r.head_valid = hv;
        r.head_task = ht;
        r.is_full = full;
        return r;
    endfunction

    function automatic void add_row(sprq_in_t op, bit typed, sprq_out_t want);
        drow_t d;
        d.op = op;
        d.typed = typed;
        d.want = want;
        dir_rows.push_back(d);
    endfunction

    // Random operation shaped by the current traffic mix
    function automatic sprq_in_t rand_op(mix_t m);
        sprq_in_t op;
        int r;
        int ins_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        case (m)
            MIX_FILL:  begin ins_lim = 70; pop_lim = 80; end
            MIX_DRAIN: begin ins_lim = 25; pop_lim = 60; end
            default:   begin ins_lim = 45; pop_lim = 65; end
        endcase
        op.task_id = TASK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                        : $urandom_range(0, 255));
        op.priority_req = PRIO_W'(($urandom_range(0, 2) == 0) ? 8'h55 * $urandom_range(0, 3)
                                                              : $urandom_range(0, 255));
        if (r < ins_lim)
            op.action = ACT_INSERT;
        else if (r < pop_lim)
            op.action = ACT_POP;
        else if (r < 97) begin
            op.action = ACT_REMOVE;
            // mostly aim at an id that is queued so removals hit
            if (queue_len > 0 && $urandom_range(0, 3) != 0)
                op.task_id = queue_task[$urandom_range(0, queue_len - 1)];
        end else
            op.action = action_t'(ACT_UNDEF);
        return op;
    endfunction

    // Present one transaction, with a random gap whenever a burst runs out
    task automatic send_op(sprq_in_t op, bit typed, sprq_out_t want);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 20);
            else
                gap = $urandom_range(1, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
            mix = mix_t'($urandom_range(0, 2));
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_data     <= op;
        typed_now  <= typed;
        typed_want <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the input off until every outstanding result has come back
    task automatic wait_empty();
        s_valid <= 1'b0;
        do @(negedge aclk); while (result_q.size() != 0);
        @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic flag(string fld, logic [TASK_W-1:0] want, logic [TASK_W-1:0] got);
        err_cnt++;
        if (err_cnt <= MAX_REPORT)
            $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
    endtask

    // Result checker and predictor hook; results are popped before new pushes
    always @(posedge aclk) begin
        sprq_out_t want;
        sprq_out_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORT)
                        $display("%0t: result %h with no transaction pending", $time, m_data);
                end else begin
                    want = result_q.pop_front();
                    if (m_data.success !== want.success)
                        flag("success", want.success, m_data.success);
                    if (m_data.removed_task !== want.removed_task)
                        flag("removed_task", want.removed_task, m_data.removed_task);
                    if (m_data.head_valid !== want.head_valid)
                        flag("head_valid", want.head_valid, m_data.head_valid);
                    if (m_data.head_task !== want.head_task)
                        flag("head_task", want.head_task, m_data.head_task);
                    if (m_data.is_full !== want.is_full)
                        flag("is_full", want.is_full, m_data.is_full);
                end
            end
            if (s_valid && s_ready) begin
                pred = predict_queue(s_data);
                result_q.push_back(typed_now ? typed_want : pred);
            end
        end
    end

    // Receiver stall pattern: the mode is redrawn whenever its random hold count runs out
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 9) < 7);
            2: m_ready <= (cyc % 5 != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Timeout
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYC_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int i;
        int k;
        sprq_out_t none;
        none = '0;
        for (k = 0; k < QDEPTH; k++) begin
            queue_prio[k] = '0;
            queue_task[k] = '0;
        end

        // Empty-queue cases, task id 0 and the field extremes
        add_row(mk_op(ACT_POP, 8'h00, 8'h00), 1, mk_res(0, 8'h00, 0, 8'h00, 0));
        add_row(mk_op(ACT_REMOVE, 8'h07, 8'h00), 1, mk_res(0, 8'h00, 0, 8'h00, 0));
        add_row(mk_op(ACT_INSERT, 8'h00, 8'h00), 1, mk_res(1, 8'h00, 1, 8'h00, 0));
        add_row(mk_op(ACT_REMOVE, 8'h00, 8'hFF), 1, mk_res(1, 8'h00, 0, 8'h00, 0));
        add_row(mk_op(ACT_INSERT, 8'hFF, 8'hFF), 1, mk_res(1, 8'h00, 1, 8'hFF, 0));
        add_row(mk_op(ACT_POP, 8'hFF, 8'hFF), 1, mk_res(1, 8'hFF, 0, 8'h00, 0));
        // Fill to capacity with ties and a duplicated id
        for (i = 0; i < QDEPTH; i++) begin
            add_row(mk_op(ACT_INSERT, TASK_W'((i == 3 || i == 11) ? 8'h42 : 8'h10 + i),
                          PRIO_W'((i == 0) ? 8'h00 : (i == 15) ? 8'hFF :
                                  (i % 3 == 0) ? 8'h80 : (i % 3 == 1) ? 8'hF0 - i : 8'h01)),
                    0, none);
        end
        // Full insert, undefined code, duplicate id, absent id, pop
        add_row(mk_op(ACT_INSERT, 8'hAA, 8'h80), 0, none);
        add_row(mk_op(action_t'(ACT_UNDEF), 8'hFF, 8'hFF), 0, none);
        add_row(mk_op(ACT_REMOVE, 8'h42, 8'h00), 0, none);
        add_row(mk_op(ACT_REMOVE, 8'h99, 8'h00), 0, none);
        add_row(mk_op(ACT_POP, 8'h00, 8'h00), 0, none);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
        wait_empty();

        for (i = 0; i < RAND_ITEMS; i++) begin
            send_op(rand_op(mix), 1'b0, none);
            if (i == RAND_ITEMS / 2)
                wait_empty();
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (result_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sorted_priority_ready_queue_core.f =====
hdl/sprq_pkg.sv
hdl/sprq_cell.sv
hdl/sorted_priority_ready_queue_core.sv
tb/testbench.sv
